// ===== rtl/mirq_pkg.sv =====
// ----------------------------------------------------------------------------
// mirq_pkg
// shared types, command codes, register addresses and exram modes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mirq_pkg;

    // item command codes
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_LINE  = 2'd2,
        CMD_STOP  = 2'd3
    } t_cmd;

    // exram access modes
    localparam logic [1:0] MODE_RAM_RW = 2'd2;
    localparam logic [1:0] MODE_RAM_RO = 2'd3;
    localparam logic [7:0] MODE_MASK   = 8'h03;

    // cpu register addresses
    localparam logic [15:0] ADDR_MODE  = 16'h5104;
    localparam logic [15:0] ADDR_CMP   = 16'h5203;
    localparam logic [15:0] ADDR_STAT  = 16'h5204;
    localparam logic [15:0] ADDR_MULA  = 16'h5205;
    localparam logic [15:0] ADDR_MULB  = 16'h5206;
    localparam logic [15:0] EXRAM_BASE = 16'h5C00;
    localparam logic [15:0] EXRAM_LAST = 16'h5FFF;

    // status and enable bit positions
    localparam int STAT_PEND_BIT  = 7;
    localparam int STAT_FRAME_BIT = 6;
    localparam int EN_BIT         = 7;

    localparam int         EXRAM_DEPTH_DEF = 1024;
    localparam logic [7:0] EXRAM_FILL      = 8'hFF;

endpackage

// ===== rtl/mirq_exram.sv =====
// ----------------------------------------------------------------------------
// mirq_exram
// expansion ram: one write port, one registered read port, fill after reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mirq_exram #(
    parameter int EXRAM_DEPTH = mirq_pkg::EXRAM_DEPTH_DEF,
    localparam int IDX_W = $clog2(EXRAM_DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_widx,
    input  logic [7:0]       i_wdata,
    input  logic             i_re,
    input  logic [IDX_W-1:0] i_ridx,
    output logic [7:0]       o_rdata,
    output logic             o_busy
);

    logic [7:0]       r_mem [EXRAM_DEPTH];
    logic [7:0]       r_rdata;
    logic             r_clr_busy;
    logic [IDX_W-1:0] r_clr_idx;

    logic             mem_we;
    logic [IDX_W-1:0] mem_idx;
    logic [7:0]       mem_data;

    // fill pass owns the write port until done
    always_comb begin
        if (r_clr_busy) begin
            mem_we   = 1'b1;
            mem_idx  = r_clr_idx;
            mem_data = mirq_pkg::EXRAM_FILL;
        end else begin
            mem_we   = i_we;
            mem_idx  = i_widx;
            mem_data = i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == IDX_W'(EXRAM_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_idx] <= mem_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_ridx];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clr_busy;

endmodule

// ===== rtl/mirq_regs.sv =====
// ----------------------------------------------------------------------------
// mirq_regs
// irq, multiplier and mode registers; decodes one item and forms its result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mirq_regs #(
    parameter int EXRAM_DEPTH = mirq_pkg::EXRAM_DEPTH_DEF,
    localparam int IDX_W = $clog2(EXRAM_DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_commit,
    input  logic [1:0]       i_command,
    input  logic [15:0]      i_address,
    input  logic [7:0]       i_write_data,
    input  logic [7:0]       i_ram_rdata,
    output logic [7:0]       o_read_data,
    output logic             o_irq,
    output logic             o_ram_we,
    output logic [IDX_W-1:0] o_ram_widx,
    output logic [7:0]       o_ram_wdata
);

    logic       r_irq_enable, n_irq_enable;
    logic       r_irq_pending, n_irq_pending;
    logic       r_in_frame, n_in_frame;
    logic       r_irq_line, n_irq_line;
    logic [7:0] r_line_count, n_line_count;
    logic [7:0] r_compare_line, n_compare_line;
    logic [7:0] r_factor_a, n_factor_a;
    logic [7:0] r_factor_b, n_factor_b;
    logic [1:0] r_exram_mode, n_exram_mode;

    logic [15:0] product;
    logic [15:0] ram_off;
    logic        in_exram;
    logic        mode_gated;
    logic [7:0]  line_inc;
    logic [7:0]  rd;
    logic        ram_we;
    logic [7:0]  ram_wdata;

    assign product    = 16'(r_factor_a) * 16'(r_factor_b);
    assign ram_off    = i_address - mirq_pkg::EXRAM_BASE;
    assign in_exram   = (i_address >= mirq_pkg::EXRAM_BASE) &&
                        (i_address <= mirq_pkg::EXRAM_LAST);
    assign mode_gated = (r_exram_mode != mirq_pkg::MODE_RAM_RW) &&
                        (r_exram_mode != mirq_pkg::MODE_RAM_RO);
    assign line_inc   = r_line_count + 8'd1;

    always_comb begin
        n_irq_enable   = r_irq_enable;
        n_irq_pending  = r_irq_pending;
        n_in_frame     = r_in_frame;
        n_irq_line     = r_irq_line;
        n_line_count   = r_line_count;
        n_compare_line = r_compare_line;
        n_factor_a     = r_factor_a;
        n_factor_b     = r_factor_b;
        n_exram_mode   = r_exram_mode;
        rd             = 8'h00;
        ram_we         = 1'b0;
        ram_wdata      = i_write_data;

        case (mirq_pkg::t_cmd'(i_command))
            mirq_pkg::CMD_WRITE: begin
                if (i_address == mirq_pkg::ADDR_MODE) begin
                    n_exram_mode = 2'(i_write_data & mirq_pkg::MODE_MASK);
                end else if (i_address == mirq_pkg::ADDR_CMP) begin
                    n_compare_line = i_write_data;
                end else if (i_address == mirq_pkg::ADDR_STAT) begin
                    n_irq_enable = i_write_data[mirq_pkg::EN_BIT];
                    if (i_write_data[mirq_pkg::EN_BIT] && r_irq_pending) begin
                        n_irq_line = 1'b1;
                    end
                end else if (i_address == mirq_pkg::ADDR_MULA) begin
                    n_factor_a = i_write_data;
                end else if (i_address == mirq_pkg::ADDR_MULB) begin
                    n_factor_b = i_write_data;
                end else if (in_exram) begin
                    if (mode_gated) begin
                        ram_we    = 1'b1;
                        ram_wdata = r_in_frame ? i_write_data : 8'h00;
                    end else if (r_exram_mode == mirq_pkg::MODE_RAM_RW) begin
                        ram_we = 1'b1;
                    end
                end
            end
            mirq_pkg::CMD_READ: begin
                if (i_address == mirq_pkg::ADDR_STAT) begin
                    rd[mirq_pkg::STAT_PEND_BIT]  = r_irq_pending;
                    rd[mirq_pkg::STAT_FRAME_BIT] = r_in_frame;
                    n_irq_pending = 1'b0;
                    n_irq_line    = 1'b0;
                end else if (i_address == mirq_pkg::ADDR_MULA) begin
                    rd = product[7:0];
                end else if (i_address == mirq_pkg::ADDR_MULB) begin
                    rd = product[15:8];
                end else if (in_exram && !mode_gated) begin
                    rd = i_ram_rdata;
                end
            end
            mirq_pkg::CMD_LINE: begin
                if (!r_in_frame) begin
                    n_in_frame    = 1'b1;
                    n_irq_pending = 1'b0;
                    n_line_count  = 8'd0;
                    n_irq_line    = 1'b0;
                end else begin
                    n_line_count = line_inc;
                    if (line_inc == r_compare_line) begin
                        n_irq_pending = 1'b1;
                        if (r_irq_enable) begin
                            n_irq_line = 1'b1;
                        end
                    end
                end
            end
            mirq_pkg::CMD_STOP: begin
                n_in_frame = 1'b0;
            end
            default: begin
                n_in_frame = r_in_frame;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_enable   <= 1'b0;
            r_irq_pending  <= 1'b0;
            r_in_frame     <= 1'b0;
            r_irq_line     <= 1'b0;
            r_line_count   <= 8'd0;
            r_compare_line <= 8'd0;
            r_factor_a     <= 8'd0;
            r_factor_b     <= 8'd0;
            r_exram_mode   <= 2'd0;
        end else if (i_commit) begin
            r_irq_enable   <= n_irq_enable;
            r_irq_pending  <= n_irq_pending;
            r_in_frame     <= n_in_frame;
            r_irq_line     <= n_irq_line;
            r_line_count   <= n_line_count;
            r_compare_line <= n_compare_line;
            r_factor_a     <= n_factor_a;
            r_factor_b     <= n_factor_b;
            r_exram_mode   <= n_exram_mode;
        end
    end

    assign o_read_data = rd;
    assign o_irq       = n_irq_line;
    assign o_ram_we    = ram_we && i_commit;
    assign o_ram_widx  = ram_off[IDX_W-1:0];
    assign o_ram_wdata = ram_wdata;

endmodule

// ===== rtl/mapper_irq_multiplier_registers.sv =====
// ----------------------------------------------------------------------------
// mapper_irq_multiplier_registers
// pipeline: an accepted item passes the input stage and then the result register
//   (two register stages: input stage, result register)
// throughput: one item per cycle while o_stall is low; the exram read port is issued
//   at acceptance. reset: synchronous, active low; afterwards a fill pass writes 0xFF
//   to every exram entry, with o_stall held high
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mapper_irq_multiplier_registers #(
    parameter int EXRAM_DEPTH = mirq_pkg::EXRAM_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    // result item channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_read_data,
    output logic        o_irq_out
);

    localparam int IDX_W = $clog2(EXRAM_DEPTH);

    // input stage
    logic        r_s1_valid;
    logic [1:0]  r_s1_cmd;
    logic [15:0] r_s1_addr;
    logic [7:0]  r_s1_data;

    // write-to-read bypass for the exram byte read at acceptance
    logic        r_fwd_hit;
    logic [7:0]  r_fwd_data;

    // result register
    logic        r_out_valid;
    logic [7:0]  r_out_rd;
    logic        r_out_irq;

    logic             accept;
    logic             s1_adv;
    logic             ram_busy;
    logic [15:0]      rd_off;
    logic [IDX_W-1:0] rd_idx;
    logic [7:0]       ram_rdata;
    logic [7:0]       ram_byte;
    logic             ram_we;
    logic [IDX_W-1:0] ram_widx;
    logic [7:0]       ram_wdata;
    logic [7:0]       res_rd;
    logic             res_irq;

    // stage 1 moves on whenever the result register is free or draining
    assign s1_adv  = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = ram_busy || (r_s1_valid && !s1_adv);
    assign accept  = i_valid && !o_stall;

    // exram index of the incoming address, read issued at acceptance
    assign rd_off = i_address - mirq_pkg::EXRAM_BASE;
    assign rd_idx = rd_off[IDX_W-1:0];

    mirq_exram #(
        .EXRAM_DEPTH(EXRAM_DEPTH)
    ) u_exram (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (ram_we),
        .i_widx (ram_widx),
        .i_wdata(ram_wdata),
        .i_re   (accept),
        .i_ridx (rd_idx),
        .o_rdata(ram_rdata),
        .o_busy (ram_busy)
    );

    // a write committing in the same cycle as the read must win
    assign ram_byte = r_fwd_hit ? r_fwd_data : ram_rdata;

    mirq_regs #(
        .EXRAM_DEPTH(EXRAM_DEPTH)
    ) u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_commit    (s1_adv),
        .i_command   (r_s1_cmd),
        .i_address   (r_s1_addr),
        .i_write_data(r_s1_data),
        .i_ram_rdata (ram_byte),
        .o_read_data (res_rd),
        .o_irq       (res_irq),
        .o_ram_we    (ram_we),
        .o_ram_widx  (ram_widx),
        .o_ram_wdata (ram_wdata)
    );

    // input stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // input stage payload and bypass capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cmd   <= i_command;
            r_s1_addr  <= i_address;
            r_s1_data  <= i_write_data;
            r_fwd_hit  <= ram_we && (ram_widx == rd_idx);
            r_fwd_data <= ram_wdata;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_rd  <= res_rd;
            r_out_irq <= res_irq;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_rd;
    assign o_irq_out   = r_out_irq;

endmodule
